>>> hw/rtl/frustum_cull_test_core_macros.svh
// assertion macros shared by the frustum cull test rtl
// included by the modules that carry concurrent checks; no other dependencies
`ifndef FRUSTUM_CULL_TEST_CORE_MACROS_SVH
`define FRUSTUM_CULL_TEST_CORE_MACROS_SVH
`ifndef SYNTHESIS
// property must hold at every rising clock edge out of reset
`define FCT_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("fct assertion failed");
// condition must never be seen out of reset
`define FCT_ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("fct forbidden condition seen");
`else
`define FCT_ASSERT(lbl, clk, rstn, prop)
`define FCT_ASSERT_NEVER(lbl, clk, rstn, cond)
`endif
`endif

>>> hw/rtl/fct_pkg.sv
// frustum cull test package: widths, command codes, plane and item types
// no dependencies; used by every other rtl file of the block but fct_out_if and the macro header
`timescale 1ns / 1ps

package fct_pkg;

  // number formats
  localparam int COORD_W    = 16;
  localparam int COORD_FRAC = 8;
  localparam int COEF_W     = 16;
  localparam int COEF_FRAC  = 11;
  localparam int HALF_W     = COORD_W - 1;

  // datapath widths, sized so that every sum stays exact
  localparam int PROD_W = COORD_W + COEF_W;
  localparam int DSH_W  = COEF_W + COORD_FRAC;
  localparam int DIST_W = PROD_W + 2;
  localparam int EPRD_W = COEF_W + HALF_W;
  localparam int EXT_W  = EPRD_W + 2;
  localparam int RAD_W  = HALF_W + COEF_FRAC;
  localparam int CMP_W  = DIST_W + 2;

  // configuration space
  localparam int PLANE_CNT = 6;
  localparam int CFG_IDX_W = $clog2(PLANE_CNT);
  localparam int CFG_W     = 4 * COEF_W;

  // decoupling queue
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // command codes
  localparam logic [1:0] CMD_POINT  = 2'd0;
  localparam logic [1:0] CMD_SPHERE = 2'd1;
  localparam logic [1:0] CMD_BOX    = 2'd2;
  localparam logic [1:0] CMD_RSVD   = 2'd3;

  typedef enum logic [1:0] {
    KIND_POINT,
    KIND_SPHERE,
    KIND_BOX
  } kind_e;

  // one plane register: d in the top bits, a in the bottom bits
  typedef struct packed {
    logic signed [COEF_W-1:0] d;
    logic signed [COEF_W-1:0] c;
    logic signed [COEF_W-1:0] b;
    logic signed [COEF_W-1:0] a;
  } plane_t;

  // classified word as it travels from the front to the back
  typedef struct packed {
    kind_e                     kind;
    logic signed [COORD_W-1:0] center_x;
    logic signed [COORD_W-1:0] center_y;
    logic signed [COORD_W-1:0] center_z;
    logic [HALF_W-1:0]         half_x;
    logic [HALF_W-1:0]         half_y;
    logic [HALF_W-1:0]         half_z;
    logic [HALF_W-1:0]         radius;
  } item_t;

endpackage

>>> hw/rtl/fct_in_if.sv
// input channel of the frustum cull test: valid, ready and one object word
// depends on fct_pkg for the field widths
`timescale 1ns / 1ps

interface fct_in_if;
  logic                               valid;
  logic                               ready;
  logic [1:0]                         cmd;
  logic signed [fct_pkg::COORD_W-1:0] center_x;
  logic signed [fct_pkg::COORD_W-1:0] center_y;
  logic signed [fct_pkg::COORD_W-1:0] center_z;
  logic [fct_pkg::HALF_W-1:0]         half_x;
  logic [fct_pkg::HALF_W-1:0]         half_y;
  logic [fct_pkg::HALF_W-1:0]         half_z;
  logic [fct_pkg::HALF_W-1:0]         radius;

  modport source (
    output valid, cmd, center_x, center_y, center_z, half_x, half_y, half_z, radius,
    input  ready
  );

  modport sink (
    input  valid, cmd, center_x, center_y, center_z, half_x, half_y, half_z, radius,
    output ready
  );
endinterface

>>> hw/rtl/fct_out_if.sv
// result channel of the frustum cull test: valid, ready and the visible flag
// no dependencies
`timescale 1ns / 1ps

interface fct_out_if;
  logic valid;
  logic ready;
  logic visible;

  modport source (
    output valid, visible,
    input  ready
  );

  modport sink (
    input  valid, visible,
    output ready
  );
endinterface

>>> hw/rtl/frustum_cull_test_core.sv
// Frustum cull test core: tests points, spheres and boxes against six planes.
//
// Channels: in_if takes one object word (cmd, center, half extents, radius),
// out_if returns one visible flag per object, both valid/ready handshakes.
// Planes are written through cfg_we_i / cfg_idx_i / cfg_wdata_i, index 0..5 =
// left, right, top, bottom, near, far; higher indexes are dropped. Write them
// only while no object is in flight.
// Path: a word accepted on in_if passes the front register, the queue, the product
// stage, the sum stage and the compare register before its result shows on out_if.
// Throughput: one object per cycle while out_if.ready holds; the three-stage
// back end with its 36 multipliers takes a new word every cycle that it can move.
// Reset clears all plane registers to zero (every object visible), empties the
// queue and the pipeline. When the receiver stalls, the pipeline, the
// four-entry queue and the front register fill first; in_if.ready drops only
// when all of them are full.
// depends on fct_pkg, fct_in_if, fct_out_if, fct_front, fct_queue, fct_back
`timescale 1ns / 1ps

module frustum_cull_test_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  fct_in_if.sink                            in_if,
  fct_out_if.source                         out_if,
  input  logic                              cfg_we_i,
  input  logic [fct_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [fct_pkg::CFG_W-1:0]         cfg_wdata_i
);
  import fct_pkg::*;

  plane_t [PLANE_CNT-1:0] planes_q;
  logic                   push;
  item_t                  push_item;
  logic                   q_full;
  logic                   q_valid;
  item_t                  q_item;
  logic                   q_pop;

  // plane registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      planes_q <= '0;
    end else if (cfg_we_i && (cfg_idx_i < CFG_IDX_W'(PLANE_CNT))) begin
      planes_q[cfg_idx_i] <= cfg_wdata_i;
    end
  end

  fct_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_if       (in_if),
    .push_o      (push),
    .push_item_o (push_item),
    .full_i      (q_full)
  );

  fct_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .pop_item_o  (q_item)
  );

  fct_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .planes_i  (planes_q),
    .q_valid_i (q_valid),
    .q_item_i  (q_item),
    .q_pop_o   (q_pop),
    .out_if    (out_if)
  );

endmodule

>>> hw/rtl/fct_front.sv
// front end: accepts object words, decodes the command and hands them to the queue
// depends on fct_pkg and fct_in_if
`timescale 1ns / 1ps

module fct_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  fct_in_if.sink        in_if,
  output logic          push_o,
  output fct_pkg::item_t push_item_o,
  input  logic          full_i
);
  import fct_pkg::*;

  logic  valid_q, valid_d;
  item_t item_q;
  item_t item_d;
  logic  accept;

  // command decode, the unused code runs as a sphere
  always_comb begin
    item_d.center_x = in_if.center_x;
    item_d.center_y = in_if.center_y;
    item_d.center_z = in_if.center_z;
    item_d.half_x   = in_if.half_x;
    item_d.half_y   = in_if.half_y;
    item_d.half_z   = in_if.half_z;
    item_d.radius   = in_if.radius;
    unique case (in_if.cmd) inside
      CMD_POINT:            item_d.kind = KIND_POINT;
      CMD_BOX:              item_d.kind = KIND_BOX;
      CMD_SPHERE, CMD_RSVD: item_d.kind = KIND_SPHERE;
      default:              item_d.kind = KIND_SPHERE;
    endcase
  end

  // one holding register, drained into the queue whenever it has room
  assign push_o      = valid_q && !full_i;
  assign push_item_o = item_q;
  assign in_if.ready = !valid_q || !full_i;
  assign accept      = in_if.valid && in_if.ready;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (push_o) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_d;
    end
  end

endmodule

>>> hw/rtl/fct_queue.sv
// short fifo between front and back so that each side stalls on its own
// depends on fct_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "frustum_cull_test_core_macros.svh"

module fct_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  fct_pkg::item_t push_item_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output fct_pkg::item_t pop_item_o
);
  import fct_pkg::*;

  item_t             mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QPTR_W:0]   count_q, count_d;

  assign full_o     = (count_q == (QPTR_W+1)'(QUEUE_DEPTH));
  assign valid_o    = (count_q != '0);
  assign pop_item_o = mem_q[rd_ptr_q];

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

  `FCT_ASSERT_NEVER(a_count_over, clk_i, rst_ni, count_q > (QPTR_W+1)'(QUEUE_DEPTH))
  `FCT_ASSERT_NEVER(a_push_full, clk_i, rst_ni, push_i && full_o)
  `FCT_ASSERT(a_pop_nonempty, clk_i, rst_ni, pop_i |-> valid_o)
  `FCT_ASSERT(a_count_up, clk_i, rst_ni, push_i && !pop_i |=> count_q == $past(count_q) + 1'b1)

endmodule

>>> hw/rtl/fct_back.sv
// back end: per plane products, plane distances and cull decision in three stages
// depends on fct_pkg, fct_out_if and the assertion macro header
`timescale 1ns / 1ps
`include "frustum_cull_test_core_macros.svh"

module fct_back (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  fct_pkg::plane_t [fct_pkg::PLANE_CNT-1:0]    planes_i,
  input  logic                                        q_valid_i,
  input  fct_pkg::item_t                              q_item_i,
  output logic                                        q_pop_o,
  fct_out_if.source                                   out_if
);
  import fct_pkg::*;

  // magnitude of a coefficient, the most negative code maps to its true size
  function automatic logic [COEF_W-1:0] abs_coef(input logic signed [COEF_W-1:0] v);
    logic [COEF_W-1:0] neg;
    neg = COEF_W'(-v);
    return v[COEF_W-1] ? neg : v;
  endfunction

  // one plane's verdict: true when the object lies fully outside it
  function automatic logic plane_cull(input kind_e                    kind,
                                      input logic signed [DIST_W-1:0] pdist,
                                      input logic [EXT_W-1:0]         ext,
                                      input logic [RAD_W-1:0]         rsh);
    logic signed [CMP_W-1:0] dc;
    logic signed [CMP_W-1:0] ec;
    logic signed [CMP_W-1:0] rc;
    logic signed [CMP_W-1:0] hi;
    logic signed [CMP_W-1:0] lo;
    logic signed [CMP_W-1:0] sp;
    logic                    res;
    dc = CMP_W'(pdist);
    ec = $signed(CMP_W'(ext));
    rc = $signed(CMP_W'(rsh));
    hi = dc + ec;
    lo = dc - ec;
    sp = dc + rc;
    case (kind)
      KIND_POINT: res = dc[CMP_W-1];
      KIND_BOX:   res = (hi[CMP_W-1] || (hi == '0)) && lo[CMP_W-1];
      default:    res = sp[CMP_W-1];
    endcase
    return res;
  endfunction

  // stage enables, each stage moves when the one after it can take its word
  logic v1_q, v2_q, v3_q;
  logic en1, en2, en3;

  assign en3     = !v3_q || out_if.ready;
  assign en2     = !v2_q || en3;
  assign en1     = !v1_q || en2;
  assign q_pop_o = en1 && q_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) begin
        v1_q <= q_valid_i;
      end
      if (en2) begin
        v2_q <= v1_q;
      end
      if (en3) begin
        v3_q <= v2_q;
      end
    end
  end

  // stage 1: coordinate and extent products for every plane
  logic signed [PROD_W-1:0] pa_q [PLANE_CNT];
  logic signed [PROD_W-1:0] pb_q [PLANE_CNT];
  logic signed [PROD_W-1:0] pc_q [PLANE_CNT];
  logic [EPRD_W-1:0]        ea_q [PLANE_CNT];
  logic [EPRD_W-1:0]        eb_q [PLANE_CNT];
  logic [EPRD_W-1:0]        ec_q [PLANE_CNT];
  kind_e                    kind1_q;
  logic [HALF_W-1:0]        radius1_q;

  always_ff @(posedge clk_i) begin
    if (en1) begin
      for (int p = 0; p < PLANE_CNT; p++) begin
        pa_q[p] <= planes_i[p].a * q_item_i.center_x;
        pb_q[p] <= planes_i[p].b * q_item_i.center_y;
        pc_q[p] <= planes_i[p].c * q_item_i.center_z;
        ea_q[p] <= abs_coef(planes_i[p].a) * q_item_i.half_x;
        eb_q[p] <= abs_coef(planes_i[p].b) * q_item_i.half_y;
        ec_q[p] <= abs_coef(planes_i[p].c) * q_item_i.half_z;
      end
      kind1_q   <= q_item_i.kind;
      radius1_q <= q_item_i.radius;
    end
  end

  // stage 2: plane distance and extent sums, radius aligned to the product scale
  logic signed [DIST_W-1:0] dist_q [PLANE_CNT];
  logic [EXT_W-1:0]         ext_q  [PLANE_CNT];
  logic signed [DSH_W-1:0]  dsh    [PLANE_CNT];
  kind_e                    kind2_q;
  logic [RAD_W-1:0]         rsh2_q;

  always_comb begin
    for (int p = 0; p < PLANE_CNT; p++) begin
      dsh[p] = {planes_i[p].d, {COORD_FRAC{1'b0}}};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en2) begin
      for (int p = 0; p < PLANE_CNT; p++) begin
        dist_q[p] <= DIST_W'(pa_q[p]) + DIST_W'(pb_q[p]) + DIST_W'(pc_q[p])
                   + DIST_W'(dsh[p]);
        ext_q[p]  <= EXT_W'(ea_q[p]) + EXT_W'(eb_q[p]) + EXT_W'(ec_q[p]);
      end
      kind2_q <= kind1_q;
      rsh2_q  <= {radius1_q, {COEF_FRAC{1'b0}}};
    end
  end

  // stage 3: per plane compare and reduction into the output register
  logic [PLANE_CNT-1:0] cull;
  logic                 visible_q;

  always_comb begin
    for (int p = 0; p < PLANE_CNT; p++) begin
      cull[p] = plane_cull(kind2_q, dist_q[p], ext_q[p], rsh2_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en3) begin
      visible_q <= ~|cull;
    end
  end

  assign out_if.valid   = v3_q;
  assign out_if.visible = visible_q;

  `FCT_ASSERT(a_s1_hold, clk_i, rst_ni, v1_q && !en1 |=> v1_q)
  `FCT_ASSERT(a_s2_hold, clk_i, rst_ni, v2_q && !en2 |=> v2_q)
  `FCT_ASSERT(a_out_hold, clk_i, rst_ni, v3_q && !out_if.ready |=> v3_q && $stable(visible_q))

endmodule
